### hdl/lsbd_pkg.sv
// ----------------------------------------------------------------------------
// lsbd_pkg
// Shared types and codes for the LSB hidden-data extractor.
// ----------------------------------------------------------------------------
package lsbd_pkg;

    // Default width of the hidden length fields
    localparam int LSBD_SIZE_BITS = 32;

    // Parse phase codes
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_HEADER   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MAGIC    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXT_LEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_EXT_DATA = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA_LEN = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DATA     = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DONE     = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_EXT   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_SKIP  = 2'd0;
    localparam logic [1:0] CFG_MAGIC_WORD   = 2'd1;
    localparam logic [1:0] CFG_MAGIC_LENGTH = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  HEADER_SKIP_RST  = 8'd54;
    localparam logic [63:0] MAGIC_WORD_RST   = 64'd0;
    localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
    localparam logic [3:0]  MAGIC_MAX        = 4'd8;

    // Configuration seen by the parser
    typedef struct packed {
        logic [7:0]  header_skip;
        logic [63:0] magic_word;
        logic [3:0]  magic_length;
    } cfg_t;

    // One parse result
    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } result_t;

endpackage

### hdl/lsbd_parser.sv
// ----------------------------------------------------------------------------
// lsbd_parser
// Parse state and next-state logic: header skip, magic check, length fields
// and hidden byte runs, one image byte per step.
// ----------------------------------------------------------------------------
module lsbd_parser
    import lsbd_pkg::*;
#(
    parameter int SIZE_BITS = LSBD_SIZE_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    pixel_bit,
    input  logic    start,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int BIT_W = $clog2(SIZE_BITS);

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [BIT_W-1:0]     bit_index_reg, bit_index_next;
    logic [SIZE_BITS-1:0] shift_value_reg, shift_value_next;
    logic [SIZE_BITS-1:0] remaining_reg, remaining_next;
    logic [3:0]           magic_index_reg, magic_index_next;

    logic [3:0]           magic_len_eff;
    logic                 active;
    logic [BIT_W-1:0]     bit_last;
    logic [SIZE_BITS-1:0] value;
    logic [7:0]           want;

    // Clamp the magic length to the eight bytes of the magic word
    assign magic_len_eff = (cfg.magic_length > MAGIC_MAX) ? MAGIC_MAX : cfg.magic_length;

    // Work out the next parse state and any result for the current byte
    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        shift_value_next = shift_value_reg;
        remaining_next   = remaining_reg;
        magic_index_next = magic_index_reg;
        result           = '0;
        active           = 1'b1;
        bit_last         = BIT_W'(7);
        value            = '0;
        want             = '0;

        // Restart on a start flag
        if (start)
        begin
            phase_next       = PH_HEADER;
            bit_index_next   = '0;
            shift_value_next = '0;
            remaining_next   = '0;
            magic_index_next = '0;
        end

        // Count off header bytes
        if (phase_next == PH_HEADER)
        begin
            if (remaining_next < SIZE_BITS'(cfg.header_skip))
            begin
                remaining_next = remaining_next + 1'b1;
                active         = 1'b0;
            end
            else
            begin
                remaining_next = '0;
                phase_next     = PH_MAGIC;
            end
        end

        // Leave the magic check once enough bytes have matched
        if (active && phase_next == PH_MAGIC && magic_index_next >= magic_len_eff)
        begin
            phase_next       = PH_EXT_LEN;
            bit_index_next   = '0;
            shift_value_next = '0;
        end

        // Ignore bytes when idle or done
        if (phase_next < PH_MAGIC || phase_next > PH_DATA)
            active = 1'b0;

        if (active)
        begin
            // Gather one hidden bit, least significant first
            shift_value_next = shift_value_next
                             | (SIZE_BITS'(pixel_bit) << bit_index_next);
            if (phase_next == PH_EXT_LEN || phase_next == PH_DATA_LEN)
                bit_last = BIT_W'(SIZE_BITS - 1);

            if (bit_index_next == bit_last)
            begin
                value            = shift_value_next;
                bit_index_next   = '0;
                shift_value_next = '0;

                unique case (phase_next)
                    PH_MAGIC:
                    begin
                        want = cfg.magic_word[magic_index_next[2:0]*8 +: 8];
                        if (value[7:0] != want)
                        begin
                            phase_next  = PH_DONE;
                            result.valid = 1'b1;
                            result.kind  = KIND_ERROR;
                        end
                        else
                        begin
                            magic_index_next = magic_index_next + 1'b1;
                            if (magic_index_next >= magic_len_eff)
                                phase_next = PH_EXT_LEN;
                        end
                    end
                    PH_EXT_LEN:
                    begin
                        remaining_next = value;
                        phase_next     = (value != '0) ? PH_EXT_DATA : PH_DATA_LEN;
                    end
                    PH_DATA_LEN:
                    begin
                        remaining_next = value;
                        phase_next     = (value != '0) ? PH_DATA : PH_DONE;
                    end
                    PH_EXT_DATA, PH_DATA:
                    begin
                        result.valid    = 1'b1;
                        result.out_byte = value[7:0];
                        result.kind     = (phase_next == PH_DATA) ? KIND_DATA : KIND_EXT;
                        result.last     = (remaining_next == SIZE_BITS'(1));
                        remaining_next  = remaining_next - 1'b1;
                        if (remaining_next == '0)
                            phase_next = (phase_next == PH_DATA) ? PH_DONE : PH_DATA_LEN;
                    end
                    default:
                    begin
                        result = '0;
                    end
                endcase
            end
            else
            begin
                bit_index_next = bit_index_next + 1'b1;
            end
        end
    end

    // Advance the parse state on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            bit_index_reg   <= '0;
            shift_value_reg <= '0;
            remaining_reg   <= '0;
            magic_index_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            shift_value_reg <= shift_value_next;
            remaining_reg   <= remaining_next;
            magic_index_reg <= magic_index_next;
        end
    end

endmodule

### hdl/lsb_stego_bmp_decoder.sv
// ----------------------------------------------------------------------------
// lsb_stego_bmp_decoder
// Path: a result reaches the master side through the input register, the parse
// step and the result register, after the input transfer that causes it.
// Throughput: one image byte per cycle while the master side does not stall,
// set by the single parse step between the input and result registers.
// Reset: asynchronous, active low; parsing restarts at the header and the
// configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module lsb_stego_bmp_decoder
    import lsbd_pkg::*;
#(
    parameter int SIZE_BITS = LSBD_SIZE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Image byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_byte
    input  logic        s_tuser,   // [0] start_of_image
    // Hidden byte stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    cfg_t    cfg_reg;
    result_t result;

    logic       in_valid_reg;
    logic       in_bit_reg;
    logic       in_start_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [1:0] out_kind_reg;
    logic       out_last_reg;
    logic       step;

    // Move a byte through the parser when the result register is free
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    // Hold configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_skip  <= HEADER_SKIP_RST;
            cfg_reg.magic_word   <= MAGIC_WORD_RST;
            cfg_reg.magic_length <= MAGIC_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_SKIP:  cfg_reg.header_skip  <= cfg_data[7:0];
                CFG_MAGIC_WORD:   cfg_reg.magic_word   <= cfg_data;
                CFG_MAGIC_LENGTH: cfg_reg.magic_length <= cfg_data[3:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: take a transfer whenever the stage empties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_bit_reg   <= s_tdata[0];
            in_start_reg <= s_tuser;
        end
    end

    lsbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pixel_bit (in_bit_reg),
        .start     (in_start_reg),
        .cfg       (cfg_reg),
        .result    (result)
    );

    // Result register: load on a parse step, drop once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= result.valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg <= result.out_byte;
            out_kind_reg <= result.kind;
            out_last_reg <= result.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lsb_stego_bmp_decoder. Builds image byte streams
// that hide magic bytes, length words and payload bytes in the pixel LSBs,
// drives them through the slave stream in bursts, and checks every result
// on the master stream against a cycle-free predictor of the parser. The
// receiver stalls on its own pattern. The configuration changes only while
// the block is idle.
// ----------------------------------------------------------------------------
module testbench
    import lsbd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES  = 300;

    typedef struct packed {
        logic [7:0] pix;
        logic       sof;
    } image_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } hidden_t;

    typedef enum int {FRAME_CLEAN, FRAME_BAD_MAGIC, FRAME_CUT} frame_shape_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_HEADER_SKIP;
    logic [63:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] pixel_byte
    logic        s_tuser   = 1'b0; // [0] start_of_image
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic [1:0]  m_tuser;          // [1:0] kind
    logic        m_tlast;

    lsb_stego_bmp_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    image_t  image_q[$];
    hidden_t hidden_q[$];
    int      fails = 0;

    // Predictor copy of the configuration
    logic [7:0]  cfg_skip;
    logic [63:0] cfg_magic;
    logic [3:0]  cfg_mlen;

    // Predictor copy of the parse state
    logic [2:0]  prs_phase;
    logic [4:0]  prs_bits;
    logic [31:0] prs_acc;
    logic [31:0] prs_left;
    logic [3:0]  prs_matched;

    // Stimulus builder state
    logic        sof_pending = 1'b0;
    int          frame_cnt   = 0;
    int          frame_cap   = 32'h7fff_ffff;
    int          frame_bytes = 0;

    function automatic void clear_parse();
        prs_phase   = PH_HEADER;
        prs_bits    = '0;
        prs_acc     = '0;
        prs_left    = '0;
        prs_matched = '0;
    endfunction

    function automatic logic [3:0] magic_span();
        return (cfg_mlen > MAGIC_MAX) ? MAGIC_MAX : cfg_mlen;
    endfunction

    // Advance the parser by one image byte and queue any result it yields
    function automatic void extract_hidden(input logic [7:0] pix, input logic sof);
        logic [31:0] word;
        logic [4:0]  need;
        logic [7:0]  want;
        hidden_t     res;
        if (sof)
            clear_parse();
        if (prs_phase == PH_HEADER)
        begin
            if (prs_left < 32'(cfg_skip))
            begin
                prs_left = prs_left + 32'd1;
                return;
            end
            prs_left  = '0;
            prs_phase = PH_MAGIC;
        end
        if (prs_phase == PH_MAGIC && prs_matched >= magic_span())
        begin
            prs_phase = PH_EXT_LEN;
            prs_bits  = '0;
            prs_acc   = '0;
        end
        if (prs_phase < PH_MAGIC || prs_phase > PH_DATA)
            return;

        // Gather one hidden bit, LSB first
        prs_acc  = prs_acc | (32'(pix[0]) << prs_bits);
        prs_bits = prs_bits + 5'd1;
        need = (prs_phase == PH_EXT_LEN || prs_phase == PH_DATA_LEN) ?
               5'(LSBD_SIZE_BITS) : 5'd8;
        if (prs_bits != need)
            return;

        word     = prs_acc;
        prs_bits = '0;
        prs_acc  = '0;
        case (prs_phase)
            PH_MAGIC:
            begin
                want = cfg_magic[prs_matched[2:0]*8 +: 8];
                if (word[7:0] != want)
                begin
                    prs_phase = PH_DONE;
                    res = '{out_byte: 8'd0, kind: KIND_ERROR, last: 1'b0};
                    hidden_q.push_back(res);
                end
                else
                begin
                    prs_matched = prs_matched + 4'd1;
                    if (prs_matched >= magic_span())
                        prs_phase = PH_EXT_LEN;
                end
            end
            PH_EXT_LEN:
            begin
                prs_left  = word;
                prs_phase = (prs_left != 0) ? PH_EXT_DATA : PH_DATA_LEN;
            end
            PH_DATA_LEN:
            begin
                prs_left  = word;
                prs_phase = (prs_left != 0) ? PH_DATA : PH_DONE;
            end
            PH_EXT_DATA, PH_DATA:
            begin
                res.out_byte = word[7:0];
                res.kind     = (prs_phase == PH_DATA) ? KIND_DATA : KIND_EXT;
                res.last     = (prs_left == 32'd1);
                prs_left     = prs_left - 32'd1;
                if (prs_left == 0)
                    prs_phase = (prs_phase == PH_DATA) ? PH_DONE : PH_DATA_LEN;
                hidden_q.push_back(res);
            end
            default:
                ;
        endcase
    endfunction

    // Sender: bursts of random length with random gaps
    int     burst_left = 0;
    int     gap_left   = 0;
    image_t drv_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            // Predict on every accepted transfer
            if (s_tvalid && s_tready)
                extract_hidden(s_tdata, s_tuser);
            // Load the next item once the slot is free
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (image_q.size() > 0)
                begin
                    drv_item = image_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= drv_item.pix;
                    s_tuser  <= drv_item.sof;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that switches mode every so often
    int stall_mode = 0;
    int stall_len  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (stall_len == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_len  = $urandom_range(16, 200);
            end
            else
                stall_len = stall_len - 1;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    hidden_t got;
    hidden_t want_res;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{out_byte: m_tdata, kind: m_tuser, last: m_tlast};
            if (hidden_q.size() == 0)
            begin
                $error("unexpected result: out_byte %0h kind %0d last %0d",
                       got.out_byte, got.kind, got.last);
                fails++;
            end
            else
            begin
                want_res = hidden_q.pop_front();
                if (got.out_byte != want_res.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", want_res.out_byte, got.out_byte);
                    fails++;
                end
                if (got.kind != want_res.kind)
                begin
                    $error("kind: expected %0d, got %0d", want_res.kind, got.kind);
                    fails++;
                end
                if (got.last != want_res.last)
                begin
                    $error("last: expected %0d, got %0d", want_res.last, got.last);
                    fails++;
                end
            end
        end
    end

    // Wait until the stream is drained and every result has arrived
    task automatic settle();
        while (image_q.size() != 0 || s_tvalid || hidden_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_HEADER_SKIP:  cfg_skip  = val[7:0];
            CFG_MAGIC_WORD:   cfg_magic = val;
            CFG_MAGIC_LENGTH: cfg_mlen  = val[3:0];
            default:          ;
        endcase
    endtask

    task automatic configure(input logic [7:0] skip, input logic [63:0] word,
                             input logic [3:0] len);
        write_reg(CFG_HEADER_SKIP, 64'(skip));
        write_reg(CFG_MAGIC_WORD, word);
        write_reg(CFG_MAGIC_LENGTH, 64'(len));
    endtask

    // Queue one frame byte, carrying the pending start flag
    task automatic push_item(input logic [7:0] pix);
        image_t it;
        if (frame_cnt >= frame_cap)
            return;
        frame_cnt++;
        frame_bytes++;
        it.pix = pix;
        it.sof = sof_pending;
        sof_pending = 1'b0;
        image_q.push_back(it);
    endtask

    // Hide n bits of v, LSB first, under random upper pixel bits
    task automatic push_bits(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++)
            push_item({7'($urandom), v[k]});
    endtask

    task automatic push_runs(input logic [31:0] ext_n, input logic [31:0] data_n);
        push_bits(ext_n, 32);
        for (longint i = 0; i < longint'(ext_n) && frame_cnt < frame_cap; i++)
            push_bits($urandom, 8);
        push_bits(data_n, 32);
        for (longint i = 0; i < longint'(data_n) && frame_cnt < frame_cap; i++)
            push_bits($urandom, 8);
    endtask

    // Loose bytes: trailing garbage or noise with occasional restarts
    task automatic push_noise(input int n, input logic allow_sof);
        image_t it;
        repeat (n)
        begin
            it.pix = 8'($urandom);
            it.sof = allow_sof && ($urandom_range(0, 15) == 0);
            image_q.push_back(it);
        end
    endtask

    task automatic build_frame(input logic with_start, input frame_shape_t shape,
                               input logic [31:0] ext_n, input logic [31:0] data_n);
        int         span;
        int         bad_at;
        logic [7:0] mbyte;
        span   = magic_span();
        bad_at = (span > 0) ? $urandom_range(0, span - 1) : 0;
        if (shape == FRAME_BAD_MAGIC && span == 0)
            shape = FRAME_CLEAN;
        frame_cnt   = 0;
        frame_cap   = (shape == FRAME_CUT) ?
                      $urandom_range(1, int'(cfg_skip) + span * 8 + 96) : 32'h7fff_ffff;
        sof_pending = with_start;
        repeat (int'(cfg_skip)) push_item(8'($urandom));
        for (int m = 0; m < span; m++)
        begin
            mbyte = cfg_magic[m*8 +: 8];
            if (shape == FRAME_BAD_MAGIC && m == bad_at)
                mbyte = mbyte ^ 8'($urandom_range(1, 255));
            push_bits(32'(mbyte), 8);
        end
        push_runs(ext_n, data_n);
        frame_cap = 32'h7fff_ffff;
    endtask

    // Main sequence
    initial
    begin
        int          pick;
        int          random_start;
        logic [7:0]  skip;
        logic [3:0]  len;
        logic [63:0] word;

        cfg_skip  = HEADER_SKIP_RST;
        cfg_magic = MAGIC_WORD_RST;
        cfg_mlen  = MAGIC_LENGTH_RST;
        clear_parse();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults, first frame carries no start flag
        build_frame(1'b0, FRAME_CLEAN, 32'd1, 32'd2);
        settle();

        // Zero header skip, eight magic bytes of all ones
        configure(8'd0, 64'hffff_ffff_ffff_ffff, 4'd8);
        build_frame(1'b1, FRAME_CLEAN, 32'd2, 32'd1);
        settle();

        // Longest header, magic length above eight
        configure(8'd255, {$urandom, $urandom}, 4'd15);
        build_frame(1'b1, FRAME_CLEAN, 32'd1, 32'd2);
        settle();

        // No magic check; zero extension length, then zero data length,
        // each with trailing bytes
        configure(8'd3, 64'd0, 4'd0);
        build_frame(1'b1, FRAME_CLEAN, 32'd0, 32'd3);
        push_noise(12, 1'b0);
        build_frame(1'b1, FRAME_CLEAN, 32'd2, 32'd0);
        push_noise(12, 1'b0);
        build_frame(1'b1, FRAME_CLEAN, 32'd3, 32'd2);
        settle();

        // Magic mismatch: error, then silence until a restart
        configure(8'd5, {$urandom, $urandom}, 4'd3);
        build_frame(1'b1, FRAME_BAD_MAGIC, 32'd2, 32'd2);
        push_noise(16, 1'b0);
        build_frame(1'b1, FRAME_CLEAN, 32'd1, 32'd4);
        settle();

        // Lower the magic length below the bytes already matched
        configure(8'd2, {$urandom, $urandom}, 4'd4);
        frame_cnt   = 0;
        sof_pending = 1'b1;
        repeat (2) push_item(8'($urandom));
        for (int m = 0; m < 3; m++)
            push_bits(32'(cfg_magic[m*8 +: 8]), 8);
        settle();
        write_reg(CFG_MAGIC_LENGTH, 64'd2);
        push_runs(32'd2, 32'd3);
        settle();

        // Random phases, mostly well-formed frames with random content
        random_start = frame_bytes;
        while (frame_bytes - random_start < RANDOM_BYTES)
        begin
            skip = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(100, 255)) :
                                                  8'($urandom_range(0, 12));
            len  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(4, 15)) :
                                                  4'($urandom_range(0, 3));
            word = {$urandom, $urandom};
            configure(skip, word, len);
            repeat ($urandom_range(2, 5))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    build_frame(1'b1, FRAME_CLEAN, $urandom_range(0, 3), $urandom_range(0, 6));
                else if (pick < 80)
                    build_frame(1'b1, FRAME_BAD_MAGIC, $urandom_range(0, 3),
                                $urandom_range(0, 3));
                else if (pick < 90)
                    build_frame(1'b1, FRAME_CUT, $urandom, $urandom);
                else
                    push_noise($urandom_range(1, 20), 1'b1);
            end
            settle();
        end

        settle();
        if (fails == 0)
            $display("lsb_stego_bmp_decoder verification clean");
        else
            $display("lsb_stego_bmp_decoder verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("lsb_stego_bmp_decoder verification failed");
        $finish;
    end

endmodule

### filelist.f
hdl/lsbd_pkg.sv
hdl/lsbd_parser.sv
hdl/lsb_stego_bmp_decoder.sv
tb/testbench.sv
